// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, held off during rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mlfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfc_pkg;

  localparam logic [7:0]  START_MARKER_RST = 8'h59;  // 'Y'
  localparam logic [7:0]  END_MARKER_RST   = 8'h47;  // 'G'
  localparam logic [7:0]  WANTED_TYPE_RST  = 8'h63;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [7:0]  MIN_FRAME_LEN    = 8'd6;

  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [1:0] CFG_WANTED_TYPE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_END = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] wanted_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] byte_index;
    logic       last_byte;
    logic [1:0] frame_status;
    logic       type_match;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/marker_length_frame_crc16_checker_core.sv -----
// ----------------------------------------------------------------------------
// marker_length_frame_crc16_checker_core
// Length-delimited frame checker with CRC-16/MODBUS, byte-stream in and out.
// ----------------------------------------------------------------------------
// A result passes through the input register and the result register to out_*.
// Throughput: one byte per cycle while the sink accepts results; the frame state
//   and byte-wide CRC update are combinational between the input and result registers.
// Reset: synchronous, active low; clears both stages and the frame state,
//   markers return to 'Y' and 'G', wanted type to 0x63.
// Bytes dropped while hunting produce no result transaction.
`default_nettype none
`include "assert_macros.svh"

module marker_length_frame_crc16_checker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] frame_byte, [15:8] byte_index
  output logic             out_tlast,
  output logic [2:0]       out_tuser,  // [1:0] frame_status, [2] type_match
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  mlfc_pkg::cfg_t    cfg_r;
  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              adv;
  logic              out_free;
  logic              emit;
  mlfc_pkg::result_t res;
  mlfc_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= mlfc_pkg::START_MARKER_RST;
      cfg_r.end_marker   <= mlfc_pkg::END_MARKER_RST;
      cfg_r.wanted_type  <= mlfc_pkg::WANTED_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mlfc_pkg::CFG_START_MARKER: cfg_r.start_marker <= cfg_wdata;
        mlfc_pkg::CFG_END_MARKER:   cfg_r.end_marker   <= cfg_wdata;
        mlfc_pkg::CFG_WANTED_TYPE:  cfg_r.wanted_type  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv = byte_valid && out_free;

  mlfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .take       (adv),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  mlfc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .rx_byte (byte_q),
    .adv     (adv),
    .emit    (emit),
    .res     (res)
  );

  mlfc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .load_valid (emit),
    .load_res   (res),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .free       (out_free),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.byte_index, out_res.frame_byte};
  assign out_tlast = out_res.last_byte;
  assign out_tuser = {out_res.type_match, out_res.frame_status};

  `ASSERT_SAME(a_ready_when_out_empty, !out_tvalid, in_tready,
    "input stalled with empty result register")
  `ASSERT_SAME(a_stall_from_sink_only, byte_valid && !in_tready,
    out_tvalid && !out_tready, "input stalled without sink backpressure")
  `ASSERT_SAME(a_mid_frame_clean, out_tvalid && !out_tlast, out_tuser == 3'd0,
    "status or match set before frame end")

endmodule

`default_nettype wire

// ----- src/mlfc_in_stage.sv -----
// ----------------------------------------------------------------------------
// mlfc_in_stage
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_q
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_tready  = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- src/mlfc_parse.sv -----
// ----------------------------------------------------------------------------
// mlfc_parse
// Frame state: marker hunt, length check, CRC accumulate and end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mlfc_parse (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mlfc_pkg::cfg_t       cfg,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 adv,
  output logic                      emit,
  output mlfc_pkg::result_t         res
);

  mlfc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       len_m4, len_m3, len_m2;

  assign len_m4 = len_r - 8'd4;
  assign len_m3 = len_r - 8'd3;
  assign len_m2 = len_r - 8'd2;

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    type_nxt   = type_r;
    emit       = 1'b0;
    res        = '0;
    case (phase_r)
      mlfc_pkg::PH_LEN: begin
        emit           = 1'b1;
        res.frame_byte = rx_byte;
        res.byte_index = 8'd1;
        if (rx_byte < mlfc_pkg::MIN_FRAME_LEN) begin
          res.last_byte    = 1'b1;
          res.frame_status = mlfc_pkg::ST_BAD_LEN;
          phase_nxt        = mlfc_pkg::PH_HUNT;
        end else begin
          len_nxt   = rx_byte;
          crc_nxt   = mlfc_pkg::crc_feed(crc_r, rx_byte);
          pos_nxt   = 8'd2;
          phase_nxt = mlfc_pkg::PH_BODY;
        end
      end
      mlfc_pkg::PH_BODY: begin
        emit           = 1'b1;
        res.frame_byte = rx_byte;
        res.byte_index = pos_r;
        pos_nxt        = pos_r + 8'd1;
        if (pos_r == 8'd2) begin
          type_nxt = rx_byte;
        end
        if (pos_r <= len_m4) begin
          crc_nxt = mlfc_pkg::crc_feed(crc_r, rx_byte);
        end else if (pos_r == len_m3) begin
          crc_lo_nxt = rx_byte;
        end else if (pos_r == len_m2) begin
          crc_nxt = crc_r ^ {rx_byte, crc_lo_r};
        end else begin
          res.last_byte  = 1'b1;
          res.type_match = (type_r == cfg.wanted_type);
          if (rx_byte != cfg.end_marker) begin
            res.frame_status = mlfc_pkg::ST_BAD_END;
          end else if (crc_r != 16'h0000) begin
            res.frame_status = mlfc_pkg::ST_CRC_ERR;
          end else begin
            res.frame_status = mlfc_pkg::ST_OK;
          end
          pos_nxt   = pos_r;
          phase_nxt = mlfc_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = mlfc_pkg::PH_HUNT;
        if (rx_byte == cfg.start_marker) begin
          emit           = 1'b1;
          res.frame_byte = rx_byte;
          res.byte_index = 8'd0;
          crc_nxt        = mlfc_pkg::crc_feed(mlfc_pkg::CRC_INIT, rx_byte);
          crc_lo_nxt     = 8'd0;
          type_nxt       = 8'd0;
          len_nxt        = 8'd0;
          pos_nxt        = 8'd1;
          phase_nxt      = mlfc_pkg::PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mlfc_pkg::PH_HUNT;
      len_r    <= 8'd0;
      pos_r    <= 8'd0;
      crc_r    <= mlfc_pkg::CRC_INIT;
      crc_lo_r <= 8'd0;
      type_r   <= 8'd0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      type_r   <= type_nxt;
    end
  end

  `ASSERT_SAME(a_body_pos_in_frame, phase_r == mlfc_pkg::PH_BODY,
    (pos_r >= 8'd2) && (pos_r < len_r), "position outside frame body")
  `ASSERT_SAME(a_body_len_min, phase_r == mlfc_pkg::PH_BODY,
    len_r >= mlfc_pkg::MIN_FRAME_LEN, "frame body entered with short length")
  `ASSERT_NEXT(a_last_resyncs, adv && emit && res.last_byte,
    phase_r == mlfc_pkg::PH_HUNT, "no return to hunting after frame end")

endmodule

`default_nettype wire

// ----- src/mlfc_out_stage.sv -----
// ----------------------------------------------------------------------------
// mlfc_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              load_valid,
  input  wire mlfc_pkg::result_t load_res,
  input  wire logic              out_tready,
  output logic                   out_valid,
  output logic                   free,
  output mlfc_pkg::result_t      out_res
);

  logic              valid_r, valid_nxt;
  mlfc_pkg::result_t res_r;

  assign free      = !valid_r || out_tready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = load_valid;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

// ----- sim/marker_length_frame_crc16_checker_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_length_frame_crc16_checker_core_tb
// Streams serial bytes into the frame checker and scores every result
// transaction against a cycle-free frame predictor kept in step with the
// configuration. Directed frames cover each status and the resync case;
// random frames follow under several marker and type settings, with random
// gaps on both sides and a long result-side hold-off.
// ----------------------------------------------------------------------------

module marker_length_frame_crc16_checker_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS  = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  marker_length_frame_crc16_checker_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  logic [7:0]         serial_pending[$];
  mlfc_pkg::result_t  expected_frame_bytes[$];
  int unsigned        items_queued = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  bit                 tx_idle_on = 1'b1;
  bit                 rx_idle_on = 1'b1;
  int unsigned        rx_hold_req = 0;

  // configuration mirror
  logic [7:0]  mk_start = mlfc_pkg::START_MARKER_RST;
  logic [7:0]  mk_end = mlfc_pkg::END_MARKER_RST;
  logic [7:0]  type_wanted = mlfc_pkg::WANTED_TYPE_RST;

  // frame tracker state
  mlfc_pkg::phase_t trk_phase = mlfc_pkg::PH_HUNT;
  logic [7:0]  trk_len = '0;
  logic [7:0]  trk_pos = '0;
  logic [15:0] trk_crc = mlfc_pkg::CRC_INIT;
  logic [7:0]  trk_crc_lo = '0;
  logic [7:0]  trk_type = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  task automatic predict_frame_byte(input logic [7:0] b);
    mlfc_pkg::result_t r;
    int      p;
    int      n;
    r = '0;
    r.frame_byte = b;
    p = int'(trk_pos);
    n = int'(trk_len);
    case (trk_phase)
      mlfc_pkg::PH_LEN: begin
        r.byte_index = 8'd1;
        if (b < mlfc_pkg::MIN_FRAME_LEN) begin
          r.last_byte = 1'b1;
          r.frame_status = mlfc_pkg::ST_BAD_LEN;
          trk_phase = mlfc_pkg::PH_HUNT;
        end else begin
          trk_len = b;
          trk_crc = crc16_step(trk_crc, b);
          trk_pos = 8'd2;
          trk_phase = mlfc_pkg::PH_BODY;
        end
        expected_frame_bytes.push_back(r);
      end
      mlfc_pkg::PH_BODY: begin
        r.byte_index = trk_pos;
        if (p == 2) trk_type = b;
        if (p + 3 < n) begin
          trk_crc = crc16_step(trk_crc, b);
        end else if (p == n - 3) begin
          trk_crc_lo = b;
        end else if (p == n - 2) begin
          trk_crc = trk_crc ^ {b, trk_crc_lo};
        end else begin
          r.last_byte = 1'b1;
          if (b != mk_end) begin
            r.frame_status = mlfc_pkg::ST_BAD_END;
          end else if (trk_crc != 16'h0000) begin
            r.frame_status = mlfc_pkg::ST_CRC_ERR;
          end else begin
            r.frame_status = mlfc_pkg::ST_OK;
          end
          r.type_match = (trk_type == type_wanted);
          trk_phase = mlfc_pkg::PH_HUNT;
        end
        if (!r.last_byte) trk_pos = trk_pos + 8'd1;
        expected_frame_bytes.push_back(r);
      end
      default: begin
        if (b == mk_start) begin
          trk_crc = crc16_step(mlfc_pkg::CRC_INIT, b);
          trk_crc_lo = '0;
          trk_type = '0;
          trk_len = '0;
          trk_pos = 8'd1;
          trk_phase = mlfc_pkg::PH_LEN;
          expected_frame_bytes.push_back(r);
        end else begin
          trk_phase = mlfc_pkg::PH_HUNT;
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input mlfc_pkg::result_t want,
                               input mlfc_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%0t %s: byte/index/last/status/match expected %02h/%0d/%0b/%0d/%0b",
             $time, what, want.frame_byte, want.byte_index, want.last_byte,
             want.frame_status, want.type_match);
      $display(", got %02h/%0d/%0b/%0d/%0b", got.frame_byte, got.byte_index,
               got.last_byte, got.frame_status, got.type_match);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    serial_pending.push_back(b);
    items_queued++;
  endtask

  // lengths below the minimum queue only the marker and the length byte
  task automatic queue_frame(input int unsigned len, input logic [7:0] ftype,
                             input logic [15:0] crc_flip, input logic [7:0] tail);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    fb.push_back(mk_start);
    fb.push_back(8'(len));
    if (len >= int'(mlfc_pkg::MIN_FRAME_LEN)) begin
      fb.push_back(ftype);
      for (int unsigned k = 3; k + 3 < len; k++) fb.push_back(8'($urandom_range(0, 255)));
      crc = mlfc_pkg::CRC_INIT;
      foreach (fb[i]) crc = crc16_step(crc, fb[i]);
      crc = crc ^ crc_flip;
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      fb.push_back(tail);
    end
    foreach (fb[i]) push_byte(fb[i]);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (serial_pending.size() != 0 || in_tvalid || expected_frame_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mlfc_pkg::CFG_START_MARKER: mk_start = val;
      mlfc_pkg::CFG_END_MARKER:   mk_end = val;
      mlfc_pkg::CFG_WANTED_TYPE:  type_wanted = val;
      default: ;
    endcase
  endtask

  task automatic run_setting(input logic [7:0] s, input logic [7:0] e, input logic [7:0] t,
                             input int unsigned n_items);
    int unsigned first;
    int unsigned roll;
    int unsigned len;
    logic [7:0]  ftype;
    logic [7:0]  tail;
    logic [7:0]  noise;
    wait_drained();
    write_reg(mlfc_pkg::CFG_START_MARKER, s);
    write_reg(mlfc_pkg::CFG_END_MARKER, e);
    write_reg(mlfc_pkg::CFG_WANTED_TYPE, t);
    rx_hold_req = 64;
    first = items_queued;
    while (items_queued - first < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(17, 60) : $urandom_range(6, 16);
      ftype = ($urandom_range(0, 1) != 0) ? type_wanted : 8'($urandom_range(0, 255));
      tail = ($urandom_range(0, 1) != 0) ? mk_start : 8'($urandom_range(0, 255));
      if (tail == mk_end) tail = ~mk_end;
      if (roll < 70) begin
        queue_frame(len, ftype, 16'h0000, mk_end);
      end else if (roll < 80) begin
        queue_frame(len, ftype, 16'($urandom_range(1, 16'hFFFF)), mk_end);
      end else if (roll < 86) begin
        queue_frame(len, ftype, 16'h0000, tail);
      end else if (roll < 90) begin
        queue_frame(len, ftype, 16'($urandom_range(1, 16'hFFFF)), tail);
      end else if (roll < 95) begin
        queue_frame($urandom_range(0, 5), ftype, 16'h0000, mk_end);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == mk_start && $urandom_range(0, 3) != 0) noise = noise ^ 8'h01;
          push_byte(noise);
        end
      end
    end
  endtask

  always @(posedge clk) begin : serial_drive
    int unsigned tx_wait;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_tvalid && in_tready) predict_frame_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (serial_pending.size() != 0) begin
          in_tdata <= serial_pending.pop_front();
          in_tvalid <= 1'b1;
          tx_wait = tx_idle_on ? $urandom_range(0, 3) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    mlfc_pkg::result_t got;
    mlfc_pkg::result_t want;
    int unsigned rx_wait;
    int unsigned rx_hold_left;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
      rx_hold_left = 0;
    end else begin
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (out_tvalid && out_tready) begin
        got.frame_byte = out_tdata[7:0];
        got.byte_index = out_tdata[15:8];
        got.last_byte = out_tlast;
        got.frame_status = out_tuser[1:0];
        got.type_match = out_tuser[2];
        if (expected_frame_bytes.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_frame_bytes.pop_front();
          if (got.frame_byte !== want.frame_byte || got.byte_index !== want.byte_index ||
              got.last_byte !== want.last_byte || got.frame_status !== want.frame_status ||
              got.type_match !== want.type_match)
            note_mismatch("mismatch", want, got);
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(8'h00);
    push_byte(8'hFF);
    queue_frame(6, mlfc_pkg::WANTED_TYPE_RST, 16'h0000, mlfc_pkg::END_MARKER_RST);
    queue_frame(5, mlfc_pkg::WANTED_TYPE_RST, 16'h0000, mlfc_pkg::END_MARKER_RST);
    queue_frame(0, mlfc_pkg::WANTED_TYPE_RST, 16'h0000, mlfc_pkg::END_MARKER_RST);
    queue_frame(6, 8'hFF, 16'h0001, mlfc_pkg::END_MARKER_RST);
    queue_frame(6, mlfc_pkg::WANTED_TYPE_RST, 16'h8000, mlfc_pkg::START_MARKER_RST);

    run_setting(mlfc_pkg::START_MARKER_RST, mlfc_pkg::END_MARKER_RST,
                mlfc_pkg::WANTED_TYPE_RST, PHASE_ITEMS);
    run_setting(8'h00, 8'h00, 8'h00, PHASE_ITEMS);
    run_setting(8'hFF, 8'hFF, 8'hFF, PHASE_ITEMS);
    queue_frame(255, 8'hFF, 16'h0000, 8'hFF);
    run_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), PHASE_ITEMS);
    run_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), PHASE_ITEMS);
    wait_drained();

    if (expected_frame_bytes.size() != 0) begin
      $display("%0d expected results never arrived", expected_frame_bytes.size());
      mismatch_count += expected_frame_bytes.size();
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
